[design/glpc_pkg.sv]
// Shared types and constants for the grid letter pair counter.
// Used by glpc_grid_ram and grid_letter_pair_counter; depends on nothing.
package glpc_pkg;

   localparam int MAX_SIDE  = 64;
   localparam int SIDE_BITS = $clog2(MAX_SIDE);
   localparam int ADDR_BITS = 2 * SIDE_BITS;
   localparam int EXT_BITS  = 7;
   localparam int CNT_BITS  = 13;
   localparam int LINE_LEN  = MAX_SIDE + 1;

   localparam logic [EXT_BITS-1:0] MAX_EXTENT = EXT_BITS'(MAX_SIDE);
   localparam logic [CNT_BITS-1:0] COUNT_MAX  = {CNT_BITS{1'b1}};

   localparam logic [0:0] FUNC_WRITE = 1'b0;
   localparam logic [0:0] FUNC_QUERY = 1'b1;

   localparam logic [0:0] CSR_GRID_ROWS = 1'b0;
   localparam logic [0:0] CSR_GRID_COLS = 1'b1;

   localparam logic [2:0] DIR_DOWN       = 3'd0;
   localparam logic [2:0] DIR_UP         = 3'd1;
   localparam logic [2:0] DIR_RIGHT      = 3'd2;
   localparam logic [2:0] DIR_LEFT       = 3'd3;
   localparam logic [2:0] DIR_DOWN_RIGHT = 3'd4;
   localparam logic [2:0] DIR_UP_LEFT    = 3'd5;
   localparam logic [2:0] DIR_DOWN_LEFT  = 3'd6;
   localparam logic [2:0] DIR_UP_RIGHT   = 3'd7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      logic [7:0]           wr_data;
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
   } ram_req_type;

endpackage

[design/grid_letter_pair_counter.sv]
// Top level of the grid letter pair counter: control, scan pipeline and counters.
// Depends on glpc_pkg and glpc_grid_ram.
//
// Usage:
//   req channel: one transaction is a cell write (tuser 0) or a pair query (tuser 1).
//   A write is stored at the edge it is accepted and gives no response.
//   A query sweeps rows 0..R-1, R = min(grid_rows,64), all 64 columns of each, reading
//   one cell per cycle from the grid memory; a 65-entry line of past cells
//   supplies the left, up-left, up and up-right neighbors of each cell.
//   The first response is loaded in the EMIT state, which follows the sweep and the
//   WAIT state, or directly the query for an empty grid; with rsp_tready high the next
//   item can be accepted once the eighth response has been loaded.
//   rsp channel: eight transactions, directions 0..7, tlast on the eighth,
//   one per cycle while rsp_tready is high; a stall holds the output register,
//   the remaining counts and req_tready low.
//   req_tready is high only while no query is in progress; a new item may be
//   taken while the final response still waits in the output register.
//   csr port: write grid_rows (index 0) or grid_cols (index 1) while idle.
//   Reset (synchronous, active high) returns both sizes to 1 and clears all
//   control state; grid contents are undefined until written.
module grid_letter_pair_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // cell_row, cell_col, cell_letter, first_letter,
                                    // second_letter, zero pad
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // pair_count, zero pad
   output logic [2:0]  rsp_tuser,   // direction
   output logic        rsp_tlast,   // last
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   localparam int SB = glpc_pkg::SIDE_BITS;
   localparam int EB = glpc_pkg::EXT_BITS;
   localparam int CB = glpc_pkg::CNT_BITS;

   glpc_pkg::state_type state_ff, state_in;

   logic [EB-1:0] grid_rows_ff, grid_cols_ff;
   logic [EB-1:0] rows_ext, cols_ext;
   logic [SB-1:0] row_ff, col_ff;
   logic [7:0]    first_ff, second_ff;
   logic          d1_valid_ff, d1_last_ff;
   logic [SB-1:0] d1_row_ff, d1_col_ff;
   logic [7:0]    line_ff [0:glpc_pkg::LINE_LEN-1];
   logic [CB-1:0] cnt_ff [0:7];
   logic [2:0]    emit_idx_ff;
   logic          rsp_valid_ff, rsp_last_ff;
   logic [2:0]    rsp_dir_ff;
   logic [CB-1:0] rsp_count_ff;

   logic          req_accept, query_accept, write_accept;
   logic          issue, last_issue, load_rsp, empty_grid;
   logic [7:0]    rd_data;
   logic [7:0]    px, pl, pu, pul, pur;
   logic          v_left, v_up, v_ul, v_ur, x_active;
   logic [7:0]    inc;

   glpc_pkg::ram_req_type ram_req;

   glpc_grid_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign rows_ext = (grid_rows_ff > glpc_pkg::MAX_EXTENT) ? glpc_pkg::MAX_EXTENT : grid_rows_ff;
   assign cols_ext = (grid_cols_ff > glpc_pkg::MAX_EXTENT) ? glpc_pkg::MAX_EXTENT : grid_cols_ff;
   assign empty_grid = (rows_ext == '0) || (cols_ext == '0);

   assign req_tready   = (state_ff == glpc_pkg::ST_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign query_accept = req_accept && (req_tuser == glpc_pkg::FUNC_QUERY);
   assign write_accept = req_accept && (req_tuser == glpc_pkg::FUNC_WRITE);

   assign last_issue = (col_ff == SB'(glpc_pkg::MAX_SIDE - 1))
                    && ({1'b0, row_ff} == rows_ext - EB'(1));

   always_comb begin
      state_in = state_ff;
      issue    = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         glpc_pkg::ST_IDLE: begin
            if (query_accept) begin
               state_in = empty_grid ? glpc_pkg::ST_EMIT : glpc_pkg::ST_SCAN;
            end
         end
         glpc_pkg::ST_SCAN: begin
            issue = 1'b1;
            if (last_issue) begin
               state_in = glpc_pkg::ST_WAIT;
            end
         end
         glpc_pkg::ST_WAIT: begin
            if (d1_last_ff) begin
               state_in = glpc_pkg::ST_EMIT;
            end
         end
         glpc_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               if (emit_idx_ff == glpc_pkg::DIR_UP_RIGHT) begin
                  state_in = glpc_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = glpc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= glpc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      ram_req.wr_en   = write_accept;
      ram_req.wr_addr = {req_tdata[5:0], req_tdata[11:6]};
      ram_req.wr_data = req_tdata[19:12];
      ram_req.rd_en   = issue;
      ram_req.rd_addr = {row_ff, col_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= EB'(1);
         grid_cols_ff <= EB'(1);
      end else if (csr_we) begin
         case (csr_index)
            glpc_pkg::CSR_GRID_ROWS: grid_rows_ff <= csr_wdata;
            glpc_pkg::CSR_GRID_COLS: grid_cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (query_accept) begin
         row_ff    <= '0;
         col_ff    <= '0;
         first_ff  <= req_tdata[27:20];
         second_ff <= req_tdata[35:28];
      end else if (issue) begin
         col_ff <= col_ff + SB'(1);
         if (col_ff == SB'(glpc_pkg::MAX_SIDE - 1)) begin
            row_ff <= row_ff + SB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
         d1_last_ff  <= 1'b0;
      end else begin
         d1_valid_ff <= issue;
         d1_last_ff  <= issue && last_issue;
      end
   end

   always_ff @(posedge clock) begin
      d1_row_ff <= row_ff;
      d1_col_ff <= col_ff;
   end

   always_ff @(posedge clock) begin
      if (d1_valid_ff) begin
         line_ff[0] <= rd_data;
         for (int i = 1; i < glpc_pkg::LINE_LEN; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign px  = rd_data;
   assign pl  = line_ff[0];
   assign pur = line_ff[glpc_pkg::MAX_SIDE-2];
   assign pu  = line_ff[glpc_pkg::MAX_SIDE-1];
   assign pul = line_ff[glpc_pkg::MAX_SIDE];

   assign x_active = d1_valid_ff && ({1'b0, d1_col_ff} < cols_ext);
   assign v_left   = x_active && (d1_col_ff != '0);
   assign v_up     = x_active && (d1_row_ff != '0);
   assign v_ul     = v_left && (d1_row_ff != '0);
   assign v_ur     = d1_valid_ff && (d1_row_ff != '0)
                  && (({1'b0, d1_col_ff} + EB'(1)) < cols_ext);

   always_comb begin
      inc = '0;
      inc[glpc_pkg::DIR_LEFT]       = v_left && (px == first_ff)  && (pl == second_ff);
      inc[glpc_pkg::DIR_RIGHT]      = v_left && (pl == first_ff)  && (px == second_ff);
      inc[glpc_pkg::DIR_UP]         = v_up   && (px == first_ff)  && (pu == second_ff);
      inc[glpc_pkg::DIR_DOWN]       = v_up   && (pu == first_ff)  && (px == second_ff);
      inc[glpc_pkg::DIR_UP_LEFT]    = v_ul   && (px == first_ff)  && (pul == second_ff);
      inc[glpc_pkg::DIR_DOWN_RIGHT] = v_ul   && (pul == first_ff) && (px == second_ff);
      inc[glpc_pkg::DIR_UP_RIGHT]   = v_ur   && (px == first_ff)  && (pur == second_ff);
      inc[glpc_pkg::DIR_DOWN_LEFT]  = v_ur   && (pur == first_ff) && (px == second_ff);
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d < 8; d++) begin
         if (query_accept) begin
            cnt_ff[d] <= '0;
         end else if (inc[d] && (cnt_ff[d] != glpc_pkg::COUNT_MAX)) begin
            cnt_ff[d] <= cnt_ff[d] + CB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (query_accept) begin
            emit_idx_ff <= '0;
         end else if (load_rsp) begin
            emit_idx_ff <= emit_idx_ff + 3'd1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_dir_ff   <= emit_idx_ff;
         rsp_count_ff <= cnt_ff[emit_idx_ff];
         rsp_last_ff  <= (emit_idx_ff == glpc_pkg::DIR_UP_RIGHT);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - CB){1'b0}}, rsp_count_ff};
   assign rsp_tuser  = rsp_dir_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_last_is_final_dir: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_dir_ff == glpc_pkg::DIR_UP_RIGHT))
      else $error("tlast on a response that is not the final direction");

   a_read_from_scan: assert property (@(posedge clock) disable iff (reset)
      d1_valid_ff |-> ($past(state_ff) == glpc_pkg::ST_SCAN))
      else $error("grid read data outside a sweep");

   a_query_clears: assert property (@(posedge clock) disable iff (reset)
      query_accept |=> ((cnt_ff[0] == '0) && (cnt_ff[7] == '0) && (emit_idx_ff == '0)))
      else $error("counters not cleared at query start");

endmodule

[design/glpc_grid_ram.sv]
// Grid letter store: one write port and one registered read port.
// Depends on glpc_pkg for the address width and request struct.
module glpc_grid_ram (
   input  logic                 clock,
   input  glpc_pkg::ram_req_type ram_req,
   output logic [7:0]           rd_data
);

   logic [7:0] mem [0:(1 << glpc_pkg::ADDR_BITS)-1];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sim/grid_letter_pair_counter_tb.sv]
// Self-checking testbench for grid_letter_pair_counter: directed table, then random phases.
// Predicts the eight per-direction pair counts of each query from its own grid image,
// or takes them from the directed table; depends on glpc_pkg and the design files; reads nothing at run time.
module grid_letter_pair_counter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import glpc_pkg::*;

   localparam int STOP_AFTER  = 135;
   localparam int QUIET_AFTER = 115;
   localparam int LONG_HOLD   = 600;

   typedef struct packed {
      logic [2:0]          direction;
      logic [CNT_BITS-1:0] pair_count;
      logic                last;
   } pair_result_type;

   typedef enum {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic [0:0]                index;
      logic [6:0]                value;
      logic [0:0]                func;
      logic [5:0]                row;
      logic [5:0]                col;
      logic [7:0]                letter;
      logic [7:0]                first;
      logic [7:0]                second;
      bit                        typed;
      logic [7:0][CNT_BITS-1:0]  counts;
   } stim_row_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata   = '0;   // cell_row, cell_col, cell_letter, first_letter,
                                    // second_letter, zero pad
   logic        req_tuser   = 1'b0; // func
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;          // pair_count, zero pad
   logic [2:0]  rsp_tuser;          // direction
   logic        rsp_tlast;          // last
   logic        csr_we      = 1'b0;
   logic [0:0]  csr_index   = '0;
   logic [6:0]  csr_wdata   = '0;

   logic [7:0]      grid_image  [MAX_SIDE*MAX_SIDE];
   bit              cell_loaded [MAX_SIDE*MAX_SIDE];
   logic [6:0]      image_rows;
   logic [6:0]      image_cols;
   pair_result_type expected_results[$];
   stim_row_type    directed_rows[$];
   int              mismatches    = 0;
   int              items_sent    = 0;
   bit              quiet         = 1'b0;
   bit              long_hold_req = 1'b0;
   int              rsp_hold_left = 0;

   grid_letter_pair_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic int extent_of(logic [6:0] size_reg);
      return (size_reg > MAX_EXTENT) ? MAX_SIDE : int'(size_reg);
   endfunction

   function automatic void dir_step(input logic [2:0] dir, output int dr, output int dc);
      dr = 0;
      dc = 0;
      case (dir)
         DIR_DOWN:       begin dr =  1; dc =  0; end
         DIR_UP:         begin dr = -1; dc =  0; end
         DIR_RIGHT:      begin dr =  0; dc =  1; end
         DIR_LEFT:       begin dr =  0; dc = -1; end
         DIR_DOWN_RIGHT: begin dr =  1; dc =  1; end
         DIR_UP_LEFT:    begin dr = -1; dc = -1; end
         DIR_DOWN_LEFT:  begin dr =  1; dc = -1; end
         DIR_UP_RIGHT:   begin dr = -1; dc =  1; end
         default: ;
      endcase
   endfunction

   function automatic logic [CNT_BITS-1:0] pair_count_for(logic [2:0] dir, logic [7:0] a,
                                                           logic [7:0] b);
      int rows, cols, dr, dc, nr, nc, r, c, n;
      rows = extent_of(image_rows);
      cols = extent_of(image_cols);
      dir_step(dir, dr, dc);
      n = 0;
      for (r = 0; r < rows; r++) begin
         for (c = 0; c < cols; c++) begin
            if (grid_image[r*MAX_SIDE+c] != a) continue;
            nr = r + dr;
            nc = c + dc;
            if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
            if (grid_image[nr*MAX_SIDE+nc] == b && n < int'(COUNT_MAX)) n++;
         end
      end
      return CNT_BITS'(n);
   endfunction

   function automatic logic [7:0] pick_letter();
      return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h41 + 8'($urandom_range(0, 2));
   endfunction

   task automatic offer_item(input logic [0:0] func, input logic [5:0] row,
                             input logic [5:0] col, input logic [7:0] letter,
                             input logic [7:0] first, input logic [7:0] second,
                             input bit typed, input logic [7:0][CNT_BITS-1:0] counts);
      int gap, d;
      pair_result_type res;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {4'b0, second, first, letter, col, row};
      do @(posedge clock); while (!req_tready);
      if (func == FUNC_WRITE) begin
         grid_image[{row, col}]  = letter;
         cell_loaded[{row, col}] = 1'b1;
      end else begin
         for (d = 0; d < 8; d++) begin
            res.direction  = 3'(d);
            res.pair_count = typed ? counts[d] : pair_count_for(3'(d), first, second);
            res.last       = (3'(d) == DIR_UP_RIGHT);
            expected_results.push_back(res);
         end
      end
      items_sent++;
      if (items_sent >= QUIET_AFTER) quiet = 1'b1;
   endtask

   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] index, input logic [6:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_GRID_ROWS) image_rows = value;
      else image_cols = value;
   endtask

   task automatic add_csr(input logic [0:0] index, input logic [6:0] value);
      stim_row_type s;
      s = '{kind: ROW_CSR, index: index, value: value, func: FUNC_WRITE, row: '0, col: '0,
            letter: '0, first: '0, second: '0, typed: 1'b0, counts: '0};
      directed_rows.push_back(s);
   endtask

   task automatic add_write(input logic [5:0] row, input logic [5:0] col,
                            input logic [7:0] letter);
      stim_row_type s;
      s = '{kind: ROW_ITEM, index: '0, value: '0, func: FUNC_WRITE, row: row, col: col,
            letter: letter, first: 8'($urandom), second: 8'($urandom), typed: 1'b0,
            counts: '0};
      directed_rows.push_back(s);
   endtask

   task automatic add_query(input logic [7:0] first, input logic [7:0] second, input bit typed,
                            input logic [7:0][CNT_BITS-1:0] counts);
      stim_row_type s;
      s = '{kind: ROW_ITEM, index: '0, value: '0, func: FUNC_QUERY, row: 6'($urandom),
            col: 6'($urandom), letter: 8'($urandom), first: first, second: second,
            typed: typed, counts: counts};
      directed_rows.push_back(s);
   endtask

   always @(posedge clock) begin : rsp_side
      pair_result_type want;
      if (rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected response: direction %0d pair_count %0d last %0b",
                   rsp_tuser, rsp_tdata[CNT_BITS-1:0], rsp_tlast);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.direction) begin
               $error("direction: expected %0d, actual %0d", want.direction, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[CNT_BITS-1:0] !== want.pair_count) begin
               $error("pair_count: expected %0d, actual %0d", want.pair_count,
                      rsp_tdata[CNT_BITS-1:0]);
               mismatches++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_tlast);
               mismatches++;
            end
         end
      end
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         rsp_hold_left = LONG_HOLD;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_hold_left = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin : stimulus
      int         phase_no, n, k, r, c, pick;
      logic [6:0] rows, cols;
      bit         hold_done;

      image_rows = 7'd1;
      image_cols = 7'd1;
      foreach (cell_loaded[i]) cell_loaded[i] = 1'b0;
      foreach (grid_image[i]) grid_image[i] = 8'h00;
      hold_done = 1'b0;

      // grid starts at 1x1: a lone cell has no neighbor in any direction
      add_write(6'd0, 6'd0, 8'h41);
      add_query(8'h41, 8'h41, 1'b1, '0);
      add_query(8'h00, 8'hFF, 1'b1, '0);
      add_write(6'd63, 6'd63, 8'hFF);
      add_write(6'd63, 6'd0, 8'h00);
      add_csr(CSR_GRID_ROWS, 7'd2);
      add_csr(CSR_GRID_COLS, 7'd2);
      add_write(6'd0, 6'd1, 8'h41);
      add_write(6'd1, 6'd0, 8'h41);
      add_write(6'd1, 6'd1, 8'h41);
      add_query(8'h41, 8'h41, 1'b1,
                {13'd1, 13'd1, 13'd1, 13'd1, 13'd2, 13'd2, 13'd2, 13'd2});
      add_write(6'd1, 6'd1, 8'hFF);
      add_query(8'h41, 8'hFF, 1'b0, '0);
      add_query(8'hFF, 8'h41, 1'b0, '0);
      add_csr(CSR_GRID_ROWS, 7'd0);
      add_query(8'h41, 8'h41, 1'b1, '0);
      add_csr(CSR_GRID_ROWS, 7'd2);
      add_csr(CSR_GRID_COLS, 7'd0);
      add_query(8'h41, 8'h41, 1'b1, '0);
      add_write(6'd2, 6'd0, 8'h00);
      add_write(6'd2, 6'd1, 8'hFF);
      add_csr(CSR_GRID_ROWS, 7'd3);
      add_csr(CSR_GRID_COLS, 7'd2);
      add_query(8'hFF, 8'h00, 1'b0, '0);
      add_query(8'h00, 8'hFF, 1'b0, '0);
      add_query(8'h00, 8'h00, 1'b0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            settle_block();
            write_csr(directed_rows[i].index, directed_rows[i].value);
         end else begin
            offer_item(directed_rows[i].func, directed_rows[i].row, directed_rows[i].col,
                       directed_rows[i].letter, directed_rows[i].first,
                       directed_rows[i].second, directed_rows[i].typed,
                       directed_rows[i].counts);
         end
      end

      phase_no = 0;
      while (items_sent < STOP_AFTER) begin
         case (phase_no)
            0: begin rows = 7'd127; cols = 7'd1; end
            default: begin
               rows = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 4));
               cols = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 6));
            end
         endcase
         settle_block();
         write_csr(CSR_GRID_ROWS, rows);
         write_csr(CSR_GRID_COLS, cols);

         // load every active cell before the first query of the phase
         for (r = 0; r < extent_of(rows); r++) begin
            for (c = 0; c < extent_of(cols); c++) begin
               if (!cell_loaded[r*MAX_SIDE+c])
                  offer_item(FUNC_WRITE, 6'(r), 6'(c), pick_letter(), 8'($urandom),
                             8'($urandom), 1'b0, '0);
            end
         end

         n = (phase_no < 1) ? 3 : $urandom_range(4, 10);
         for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40 || k == 0) begin
               offer_item(FUNC_QUERY, 6'($urandom), 6'($urandom), 8'($urandom),
                          pick_letter(), pick_letter(), 1'b0, '0);
               if (phase_no >= 1 && !hold_done && k < n - 1) begin
                  long_hold_req = 1'b1;
                  hold_done     = 1'b1;
               end
            end else if (pick < 85 && extent_of(rows) > 0 && extent_of(cols) > 0) begin
               offer_item(FUNC_WRITE, 6'($urandom_range(0, extent_of(rows) - 1)),
                          6'($urandom_range(0, extent_of(cols) - 1)), pick_letter(),
                          8'($urandom), 8'($urandom), 1'b0, '0);
            end else begin
               offer_item(FUNC_WRITE, 6'($urandom), 6'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom), 1'b0, '0);
            end
         end
         phase_no++;
      end

      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
